@@ rtl/crcdf_pkg.sv @@
// ----------------------------------------------------------------------------
// crcdf_pkg
// Types, constants and the CRC-16/CCITT-FALSE byte update for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package crcdf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  typedef enum logic [2:0] {
    PH_CMD = 3'd0,
    PH_SEQ = 3'd1,
    PH_LEN = 3'd2,
    PH_PAY = 3'd3,
    PH_CLO = 3'd4,
    PH_CHI = 3'd5
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_CRC_ERR = 1'b1
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] cmd_code;
    logic [7:0] seq_num;
    logic [7:0] payload_len;
    logic       status;
  } out_item_t;

  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/crc16_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// crc16_frame_deframer_top
// Parses cmd/seq/len/payload/crc_lo/crc_hi frames from a byte stream,
// forwards payload bytes and reports a frame-end result with the CRC check.
// ----------------------------------------------------------------------------
// Latency: a result is valid on the cycle after its byte is transferred.
// Throughput: one byte per cycle; the input stalls only while a held result
//   is stalled at the output register.
// Reset: synchronous, active low; parser returns to expecting a command byte,
//   CRC to 0xFFFF, output register empty.
`default_nettype none

module crc16_frame_deframer_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire crcdf_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output crcdf_pkg::out_item_t       out_data
);
  import crcdf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic [7:0]  held_seq_r, held_seq_nxt;
  logic [7:0]  held_len_r, held_len_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        in_xfer;
  logic        res_vld;
  out_item_t   res;
  phase_t      ph;
  logic [7:0]  left_dec;
  logic [15:0] crc_upd;
  logic [15:0] crc_recv;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ph       = in_data.restart ? PH_CMD : phase_r;
    left_dec = bytes_left_r - 8'd1;
    crc_upd  = crc_add_byte((ph == PH_PAY) ? crc_r : CRC_INIT, in_data.rx_byte);
    crc_recv = {in_data.rx_byte, crc_lo_r};

    phase_nxt      = phase_r;
    held_cmd_nxt   = held_cmd_r;
    held_seq_nxt   = held_seq_r;
    held_len_nxt   = held_len_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    crc_lo_nxt     = crc_lo_r;
    res_vld        = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.payload_byte = 8'h00;
    res.cmd_code     = held_cmd_r;
    res.seq_num      = held_seq_r;
    res.payload_len  = held_len_r;
    res.status       = ST_OK;

    unique case (ph)
      PH_SEQ: begin
        held_seq_nxt = in_data.rx_byte;
        phase_nxt    = PH_LEN;
      end
      PH_LEN: begin
        held_len_nxt   = in_data.rx_byte;
        bytes_left_nxt = in_data.rx_byte;
        phase_nxt      = (in_data.rx_byte == 8'h00) ? PH_CLO : PH_PAY;
      end
      PH_PAY: begin
        crc_nxt          = crc_upd;
        bytes_left_nxt   = left_dec;
        phase_nxt        = (left_dec == 8'h00) ? PH_CLO : PH_PAY;
        res_vld          = 1'b1;
        res.payload_byte = in_data.rx_byte;
      end
      PH_CLO: begin
        crc_lo_nxt = in_data.rx_byte;
        phase_nxt  = PH_CHI;
      end
      PH_CHI: begin
        phase_nxt  = PH_CMD;
        res_vld    = 1'b1;
        res.kind   = KIND_FRAME_END;
        res.status = (crc_recv != crc_r) ? ST_CRC_ERR : ST_OK;
      end
      default: begin
        held_cmd_nxt   = in_data.rx_byte;
        held_seq_nxt   = 8'h00;
        held_len_nxt   = 8'h00;
        bytes_left_nxt = 8'h00;
        crc_lo_nxt     = 8'h00;
        crc_nxt        = crc_upd;
        phase_nxt      = PH_SEQ;
      end
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (in_xfer && res_vld) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_CMD;
      held_cmd_r   <= 8'h00;
      held_seq_r   <= 8'h00;
      held_len_r   <= 8'h00;
      bytes_left_r <= 8'h00;
      crc_r        <= CRC_INIT;
      crc_lo_r     <= 8'h00;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r      <= phase_nxt;
        held_cmd_r   <= held_cmd_nxt;
        held_seq_r   <= held_seq_nxt;
        held_len_r   <= held_len_nxt;
        bytes_left_r <= bytes_left_nxt;
        crc_r        <= crc_nxt;
        crc_lo_r     <= crc_lo_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_pay_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAY) |-> (bytes_left_r != 8'h00))
    else $error("payload phase with no bytes left");

  a_chi_gives_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_data.restart && phase_r == PH_CHI)
      |=> (out_valid_r && out_data_r.kind == KIND_FRAME_END))
    else $error("CRC high byte gave no frame-end result");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_FRAME_END) |-> (out_data_r.payload_byte == 8'h00))
    else $error("frame-end result carries a payload byte");

  a_pay_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_PAYLOAD) |-> (out_data_r.status == ST_OK))
    else $error("payload result carries an error status");

endmodule

`default_nettype wire
